### hdl/msf_pkg.sv
package msf_pkg;

    localparam int VERTEX_W    = 5;
    localparam int WEIGHT_W    = 16;
    localparam int COST_W      = 22;
    localparam int RANK_W      = 6;
    localparam int VCOUNT_W    = 6;
    localparam int DEF_MAX_VERTICES = 32;
    localparam int DEF_MAX_EDGES    = 64;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 6'd32;
    localparam logic [RANK_W-1:0]   RANK_MAX     = 6'd63;
    localparam logic [RANK_W-1:0]   RANK_INIT    = 6'd1;

    typedef struct packed {
        logic [VERTEX_W-1:0]        end_a;
        logic [VERTEX_W-1:0]        end_b;
        logic signed [WEIGHT_W-1:0] weight;
        logic                       ok;
        logic                       fin;
    } t_cmd;

    typedef struct packed {
        logic [VERTEX_W-1:0]        out_a;
        logic [VERTEX_W-1:0]        out_b;
        logic signed [WEIGHT_W-1:0] out_weight;
        logic signed [COST_W-1:0]   running_cost;
        logic                       last_result;
        logic                       none_found;
        logic                       overflow;
    } t_res;

endpackage

### hdl/msf_fifo.sv
module msf_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    // two-entry queue
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end
endmodule

### hdl/msf_front.sv
module msf_front #(
    parameter int MAX_VERTICES = msf_pkg::DEF_MAX_VERTICES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [msf_pkg::VCOUNT_W-1:0]   i_cfg_data,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [msf_pkg::VERTEX_W-1:0]   i_end_a,
    input  logic [msf_pkg::VERTEX_W-1:0]   i_end_b,
    input  logic signed [msf_pkg::WEIGHT_W-1:0] i_edge_weight,
    input  logic                           i_final_edge,
    input  logic                           i_cmd_pop,
    output msf_pkg::t_cmd                  o_cmd,
    output logic                           o_cmd_empty
);
    import msf_pkg::*;

    logic [VCOUNT_W-1:0] r_vcount;
    t_cmd                cmd;
    logic [$bits(t_cmd)-1:0] q_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCOUNT_RESET;
        end else if (i_cfg_valid) begin
            r_vcount <= i_cfg_data;
        end
    end

    // range check against both the register and the build limit
    always_comb begin
        cmd.end_a  = i_end_a;
        cmd.end_b  = i_end_b;
        cmd.weight = i_edge_weight;
        cmd.fin    = i_final_edge;
        cmd.ok     = (VCOUNT_W'(i_end_a) < r_vcount) && (VCOUNT_W'(i_end_b) < r_vcount)
                     && (32'(i_end_a) < 32'(MAX_VERTICES))
                     && (32'(i_end_b) < 32'(MAX_VERTICES));
    end

    msf_fifo #(.W($bits(t_cmd))) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (q_out),
        .o_empty (o_cmd_empty)
    );

    assign o_cmd = t_cmd'(q_out);
endmodule

### hdl/msf_back.sv
module msf_back #(
    parameter int MAX_VERTICES = msf_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = msf_pkg::DEF_MAX_EDGES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  msf_pkg::t_cmd i_cmd,
    input  logic          i_cmd_empty,
    output logic          o_cmd_pop,
    output msf_pkg::t_res o_res,
    output logic          o_res_push,
    input  logic          i_res_full
);
    import msf_pkg::*;

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_FIND  = 7'b0001000,
        S_RANK  = 7'b0010000,
        S_HIT   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic [VERTEX_W-1:0]        a;
        logic [VERTEX_W-1:0]        b;
        logic signed [WEIGHT_W-1:0] w;
    } t_edge;

    t_state r_state;
    logic [CW-1:0] r_cnt, r_scan, r_k;
    logic          r_drop, r_pend, r_best_v, r_which, r_hold_v;
    logic [MAX_EDGES-1:0] r_used;
    logic [VW-1:0] r_clr, r_x, r_ra;
    logic [EW-1:0] r_idx_d, r_best_i;
    t_edge         r_best, r_erd;
    logic [1:0]    r_ph;
    logic [RANK_W-1:0] r_rka, r_rrd;
    logic signed [COST_W-1:0] r_cost, cost_sum;
    t_res          r_hold;
    logic [VW-1:0] r_prd;

    t_edge m_edge [MAX_EDGES];
    logic [VW-1:0]     m_par  [MAX_VERTICES];
    logic [RANK_W-1:0] m_rank [MAX_VERTICES];

    logic              e_we, p_we, k_we;
    logic [VW-1:0]     p_wa, p_wd, k_wa, k_ra;
    logic [RANK_W-1:0] k_wd;
    logic              rank_a_wins;

    assign o_cmd_pop   = (r_state == S_LOAD) && !i_cmd_empty;
    assign e_we        = o_cmd_pop && i_cmd.ok && (r_cnt < CW'(MAX_EDGES));
    assign cost_sum    = r_cost + COST_W'(r_best.w);
    assign rank_a_wins = r_rka > r_rrd;
    assign k_ra        = (r_ph == 2'd0) ? r_ra : r_x;

    always_comb begin
        p_we = 1'b0; p_wa = r_clr; p_wd = r_clr;
        k_we = 1'b0; k_wa = r_clr; k_wd = RANK_INIT;
        if (r_state == S_CLEAR) begin
            p_we = 1'b1;
            k_we = 1'b1;
        end else if (r_state == S_RANK && r_ph == 2'd2) begin
            p_we = 1'b1;
            k_we = 1'b1;
            if (rank_a_wins) begin
                p_wa = r_x;  p_wd = r_ra; k_wa = r_ra;
                k_wd = (r_rka < RANK_MAX) ? r_rka + 1'b1 : r_rka;
            end else begin
                p_wa = r_ra; p_wd = r_x;  k_wa = r_x;
                k_wd = (r_rrd < RANK_MAX) ? r_rrd + 1'b1 : r_rrd;
            end
        end
    end

    always_comb begin
        o_res_push = 1'b0;
        o_res      = r_hold;
        if (r_state == S_HIT && r_hold_v) begin
            o_res_push = 1'b1;
        end else if (r_state == S_DONE) begin
            o_res_push = 1'b1;
            if (r_hold_v) begin
                o_res.last_result = 1'b1;
            end else begin
                o_res = '0;
                o_res.last_result = 1'b1;
                o_res.none_found  = 1'b1;
                o_res.overflow    = r_drop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_we) m_edge[r_cnt[EW-1:0]] <= '{a: i_cmd.end_a, b: i_cmd.end_b, w: i_cmd.weight};
        r_erd <= m_edge[r_scan[EW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (p_we) m_par[p_wa] <= p_wd;
        r_prd <= m_par[r_x];
    end

    always_ff @(posedge i_clk) begin
        if (k_we) m_rank[k_wa] <= k_wd;
        r_rrd <= m_rank[k_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_cnt    <= '0;
            r_drop   <= 1'b0;
            r_used   <= '0;
            r_hold_v <= 1'b0;
            r_pend   <= 1'b0;
            r_best_v <= 1'b0;
            r_cost   <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == VW'(MAX_VERTICES - 1)) r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (o_cmd_pop) begin
                        if (e_we) r_cnt <= r_cnt + 1'b1;
                        else      r_drop <= 1'b1;
                        if (i_cmd.fin) begin
                            r_state  <= S_SCAN;
                            r_k      <= '0;
                            r_scan   <= '0;
                            r_pend   <= 1'b0;
                            r_best_v <= 1'b0;
                        end
                    end
                end
                S_SCAN: begin
                    // find heaviest unused edge, earliest wins ties
                    if (r_k == r_cnt) begin
                        r_state <= S_DONE;
                    end else begin
                        if (r_scan < r_cnt) begin
                            r_scan  <= r_scan + 1'b1;
                            r_idx_d <= r_scan[EW-1:0];
                            r_pend  <= 1'b1;
                        end else begin
                            r_pend <= 1'b0;
                        end
                        if (r_pend && !r_used[r_idx_d]
                            && (!r_best_v || r_erd.w > r_best.w)) begin
                            r_best_v <= 1'b1;
                            r_best   <= r_erd;
                            r_best_i <= r_idx_d;
                        end
                        if (r_scan == r_cnt && !r_pend) begin
                            r_used[r_best_i] <= 1'b1;
                            r_k     <= r_k + 1'b1;
                            r_x     <= VW'(r_best.a);
                            r_which <= 1'b0;
                            r_ph    <= 2'd0;
                            r_state <= S_FIND;
                        end
                    end
                end
                S_FIND: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else if (r_prd != r_x) begin
                        r_x  <= r_prd;
                        r_ph <= 2'd0;
                    end else if (!r_which) begin
                        r_ra    <= r_x;
                        r_x     <= VW'(r_best.b);
                        r_which <= 1'b1;
                        r_ph    <= 2'd0;
                    end else begin
                        r_ph    <= 2'd0;
                        r_state <= (r_ra == r_x) ? S_HIT : S_RANK;
                    end
                end
                S_RANK: begin
                    if (r_ph == 2'd1) r_rka <= r_rrd;
                    if (r_ph == 2'd2) begin
                        r_state  <= S_SCAN;
                        r_scan   <= '0;
                        r_best_v <= 1'b0;
                        r_ph     <= 2'd0;
                    end else begin
                        r_ph <= r_ph + 1'b1;
                    end
                end
                S_HIT: begin
                    if (!r_hold_v || !i_res_full) begin
                        r_hold_v <= 1'b1;
                        r_hold   <= '{out_a: r_best.a, out_b: r_best.b,
                                      out_weight: r_best.w, running_cost: cost_sum,
                                      last_result: 1'b0, none_found: 1'b0,
                                      overflow: r_drop};
                        r_cost   <= cost_sum;
                        r_state  <= S_SCAN;
                        r_scan   <= '0;
                        r_best_v <= 1'b0;
                    end
                end
                S_DONE: begin
                    if (!i_res_full) begin
                        r_cnt    <= '0;
                        r_drop   <= 1'b0;
                        r_used   <= '0;
                        r_hold_v <= 1'b0;
                        r_cost   <= '0;
                        r_clr    <= '0;
                        r_state  <= S_CLEAR;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end
endmodule

### hdl/max_spanning_forest_cycle_edges.sv
// loading: an accepted edge word waits in the two-entry edge queue and, if in range and the edge memory
// has room, is stored when the loader pops it; a non-final word is taken every cycle while the loader is
// loading and the edge queue holds words. solve: a selection scan over the edge memory for each stored
// edge, plus a parent walk per end and a rank step per union
// reset: synchronous, active low; afterwards the forest clearing pass over all MAX_VERTICES vertices runs
// before the first edge word is stored, and the same pass runs after every solve
module max_spanning_forest_cycle_edges #(
    parameter int MAX_VERTICES = msf_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = msf_pkg::DEF_MAX_EDGES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [msf_pkg::VCOUNT_W-1:0]        i_cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic [msf_pkg::VERTEX_W-1:0]        i_end_a,
    input  logic [msf_pkg::VERTEX_W-1:0]        i_end_b,
    input  logic signed [msf_pkg::WEIGHT_W-1:0] i_edge_weight,
    input  logic                                i_final_edge,
    output logic                                empty,
    input  logic                                pop,
    output logic [msf_pkg::VERTEX_W-1:0]        o_out_a,
    output logic [msf_pkg::VERTEX_W-1:0]        o_out_b,
    output logic signed [msf_pkg::WEIGHT_W-1:0] o_out_weight,
    output logic signed [msf_pkg::COST_W-1:0]   o_running_cost,
    output logic                                o_last_result,
    output logic                                o_none_found,
    output logic                                o_overflow
);
    import msf_pkg::*;

    t_cmd cmd;
    logic cmd_empty, cmd_pop, res_push, res_full;
    t_res res_in, res_out;
    logic [$bits(t_res)-1:0] q_out;

    msf_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_cfg_data,
        .i_push (push), .o_full (full),
        .i_end_a, .i_end_b, .i_edge_weight, .i_final_edge,
        .i_cmd_pop (cmd_pop), .o_cmd (cmd), .o_cmd_empty (cmd_empty)
    );

    msf_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd (cmd), .i_cmd_empty (cmd_empty), .o_cmd_pop (cmd_pop),
        .o_res (res_in), .o_res_push (res_push), .i_res_full (res_full)
    );

    msf_fifo #(.W($bits(t_res))) u_resq (
        .i_clk, .i_rst_n,
        .i_push (res_push), .i_data (res_in), .o_full (res_full),
        .i_pop (pop), .o_data (q_out), .o_empty (empty)
    );

    assign res_out        = t_res'(q_out);
    assign o_out_a        = res_out.out_a;
    assign o_out_b        = res_out.out_b;
    assign o_out_weight   = res_out.out_weight;
    assign o_running_cost = res_out.running_cost;
    assign o_last_result  = res_out.last_result;
    assign o_none_found   = res_out.none_found;
    assign o_overflow     = res_out.overflow;
endmodule

### hdl/msf_checker.sv
module msf_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 full,
    input logic                 empty,
    input logic                 pop,
    input logic [4:0]           o_out_a,
    input logic [4:0]           o_out_b,
    input logic signed [15:0]   o_out_weight,
    input logic signed [21:0]   o_running_cost,
    input logic                 o_last_result,
    input logic                 o_none_found
);
    // nothing waits on the result side and the edge queue is not full right after reset
    a_empty_after_rst: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> empty && !full)
        else $error("queues not empty after reset");

    // a none-found word (no cycle edge in the solve) always closes the solve with zero ends, weight and cost
    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_none_found |-> o_last_result && o_out_a == 5'd0 && o_out_b == 5'd0
            && o_out_weight == 16'sd0 && o_running_cost == 22'sd0)
        else $error("none_found word malformed");

    // first feedback word of a solve has cost equal to its weight
    a_first_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(pop && !empty && o_last_result) && !empty && !o_none_found
            |-> o_running_cost == 22'(o_out_weight))
        else $error("running cost not restarted");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_running_cost) && $stable(o_out_weight))
        else $error("result word changed while waiting");
endmodule

bind max_spanning_forest_cycle_edges msf_checker u_chk (
    .i_clk, .i_rst_n, .full, .empty, .pop, .o_out_a, .o_out_b,
    .o_out_weight, .o_running_cost, .o_last_result, .o_none_found
);
